// ----- hdl/pcdr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcdr_pkg
// Shared types, constants and tables for the pixel color depth reducer.
// ----------------------------------------------------------------------------
package pcdr_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_LANES   = 4;
    localparam int DEPTH_W     = 4;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = CH_W + RECIP_W;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(CH_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOWEST  = 2'd0,
        MODE_MIDDLE  = 2'd1,
        MODE_HIGHEST = 2'd2,
        MODE_DYNAMIC = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_RED_DEPTH   = 3'd1,
        CFG_GREEN_DEPTH = 3'd2,
        CFG_BLUE_DEPTH  = 3'd3,
        CFG_ALPHA_DEPTH = 3'd4
    } cfg_idx_t;

    // per-lane settings handed to each lane
    typedef struct packed {
        mode_t               mode;
        logic [DEPTH_W-1:0]  depth;
    } lane_cfg_t;

    // ceil(2^16 / (2^d - 1)); exact floor for every numerator below 256
    function automatic logic [RECIP_W-1:0] pcdr_recip(input logic [DEPTH_W-1:0] d);
        logic [RECIP_W-1:0] r;
        begin
            case (d)
                4'd1:    r = 17'd65536;
                4'd2:    r = 17'd21846;
                4'd3:    r = 17'd9363;
                4'd4:    r = 17'd4370;
                4'd5:    r = 17'd2115;
                4'd6:    r = 17'd1041;
                4'd7:    r = 17'd517;
                4'd8:    r = 17'd258;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hdl/pcdr_lane.sv -----
// ----------------------------------------------------------------------------
// pcdr_lane
// One channel of the reducer: bin decode stage, then reciprocal multiply.
// ----------------------------------------------------------------------------
module pcdr_lane
    import pcdr_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  lane_cfg_t       cfg,
    input  logic [CH_W-1:0] pix,
    output logic [CH_W-1:0] result
);

    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] shift;
    logic [CH_W-1:0]    mask;
    logic [CH_W-1:0]    span;
    logic [CH_W-1:0]    index;
    logic [CH_W-1:0]    lowest;
    logic [CH_W-1:0]    fixed_off;

    mode_t              mode_reg;
    logic [CH_W-1:0]    lowest_reg;
    logic [CH_W-1:0]    fixed_off_reg;
    logic [CH_W-1:0]    num_reg;
    logic [RECIP_W-1:0] recip_reg;

    logic [PROD_W-1:0]  prod;
    logic [CH_W-1:0]    quot;

    always_comb
    begin
        depth  = (cfg.depth > DEPTH_MAX) ? DEPTH_MAX : cfg.depth;
        shift  = DEPTH_MAX - depth;
        mask   = {CH_W{1'b1}} << shift;
        span   = ~mask;                     // step - 1
        index  = pix >> shift;
        lowest = pix & mask;
        case (cfg.mode)
            MODE_LOWEST:  fixed_off = '0;
            MODE_MIDDLE:  fixed_off = span >> 1;
            MODE_HIGHEST: fixed_off = span;
            default:      fixed_off = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg      <= cfg.mode;
            lowest_reg    <= lowest;
            fixed_off_reg <= fixed_off;
            num_reg       <= lowest - index;   // index * (step - 1)
            recip_reg     <= pcdr_recip(depth);
        end
    end

    always_comb
    begin
        prod   = PROD_W'(num_reg) * PROD_W'(recip_reg);
        quot   = prod[RECIP_SHIFT +: CH_W];
        result = lowest_reg + ((mode_reg == MODE_DYNAMIC) ? quot : fixed_off_reg);
    end

endmodule

// ----- hdl/pixel_color_depth_reduce.sv -----
// ----------------------------------------------------------------------------
// pixel_color_depth_reduce
// Per-channel uniform quantization of RGBA8888 pixels, four lanes in parallel.
// ----------------------------------------------------------------------------
// channel   dir  payload                                      accept
// s_*       in   tdata: red, green, blue, alpha (8b each)     tvalid & tready
// m_*       out  tdata: red, green, blue, alpha (8b each)     tvalid & tready
// cfg_*     in   index 0 mode, 1..4 red/green/blue/alpha depth  cfg_we
//
// One pixel per clock while the output is not stalled; data passes the bin
// decode register, then the lane multiplier feeding the output register.
// Reset clears valid flags and sets mode lowest, all depths 8.
// An output stall holds the output register; the decode stage takes one more
// pixel only if it is empty, then s_tready drops.
// ----------------------------------------------------------------------------
module pixel_color_depth_reduce
    import pcdr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [NUM_LANES*CH_W-1:0] s_tdata,   // red, green, blue, alpha
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [NUM_LANES*CH_W-1:0] m_tdata,   // red, green, blue, alpha
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    mode_t              mode_reg;
    logic [DEPTH_W-1:0] depth_reg [NUM_LANES];

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [NUM_LANES*CH_W-1:0] out_data_reg;

    logic                      load_s1;
    logic                      load_out;
    logic [NUM_LANES*CH_W-1:0] lane_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LOWEST;
            for (int i = 0; i < NUM_LANES; i++)
                depth_reg[i] <= DEPTH_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg     <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_RED_DEPTH:   depth_reg[0] <= cfg_data;
                CFG_GREEN_DEPTH: depth_reg[1] <= cfg_data;
                CFG_BLUE_DEPTH:  depth_reg[2] <= cfg_data;
                CFG_ALPHA_DEPTH: depth_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // pipeline handshake
    always_comb
    begin
        load_out       = s1_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !s1_valid_reg || load_out;
        load_s1        = s_tvalid && s_tready;
        s1_valid_next  = load_s1 || (s1_valid_reg && !load_out);
        out_valid_next = load_out || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            lane_cfg_t lane_cfg;
            assign lane_cfg.mode  = mode_reg;
            assign lane_cfg.depth = depth_reg[g];

            pcdr_lane u_lane (
                .clk    (clk),
                .en     (load_s1),
                .cfg    (lane_cfg),
                .pix    (s_tdata[g*CH_W +: CH_W]),
                .result (lane_result[g*CH_W +: CH_W])
            );
        end
    endgenerate

    // merge lane results into the output register
    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= lane_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks pixel_color_depth_reduce on its pixel stream. Each channel of an
// accepted pixel is quantized by a local predictor using the current mode and
// depth settings, and the results are compared in order with the output
// stream. Directed passes cover reset defaults and every mode at the depth
// extremes. Random phases then change the settings and the idle patterns on
// both sides of the stream.
// ----------------------------------------------------------------------------
module testbench
    import pcdr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W      = NUM_LANES * CH_W;
    localparam int IDLE_LIMIT = 500;
    localparam int PHASES     = 30;
    localparam int PHASE_PIX  = 60;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;    // red, green, blue, alpha
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;           // red, green, blue, alpha
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // settings as the block should hold them
    mode_t               mode_reg;
    logic [DEPTH_W-1:0]  depth_reg [NUM_LANES];

    logic [PIX_W-1:0]    reduced_q [$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    int                  in_gap_max  = 5;
    int                  out_stall_max = 5;

    string lane_name [NUM_LANES] = '{"red", "green", "blue", "alpha"};

    pixel_color_depth_reduce DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // value picked from the bin that v falls in
    function automatic logic [CH_W-1:0] level_for(input logic [CH_W-1:0] v, input mode_t m,
                                                  input logic [DEPTH_W-1:0] depth);
        int unsigned d, sh, stp, bin, lo, levels;
        d      = (depth > CH_W) ? CH_W : depth;
        sh     = CH_W - d;
        stp    = 1 << sh;
        bin    = v >> sh;
        lo     = bin * stp;
        levels = (1 << d) - 1;
        case (m)
            MODE_LOWEST:  return CH_W'(lo);
            MODE_MIDDLE:  return CH_W'(lo + (stp - 1) / 2);
            MODE_HIGHEST: return CH_W'(lo + stp - 1);
            default:
            begin
                // dynamic at depth zero has no levels to spread over
                if (levels == 0)
                    return '0;
                return CH_W'(lo + (bin * (stp - 1)) / levels);
            end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] reduced_pixel(input logic [PIX_W-1:0] pix);
        logic [PIX_W-1:0] r;
        for (int i = 0; i < NUM_LANES; i++)
            r[i*CH_W +: CH_W] = level_for(pix[i*CH_W +: CH_W], mode_reg, depth_reg[i]);
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] p;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            case ($urandom_range(0, 7))
                0:       p[i*CH_W +: CH_W] = '0;
                1:       p[i*CH_W +: CH_W] = '1;
                default: p[i*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    function automatic logic [DEPTH_W-1:0] random_depth();
        if ($urandom_range(0, 5) == 0)
            return DEPTH_W'($urandom_range(9, 15));   // above eight acts as eight
        return DEPTH_W'($urandom_range(0, 8));
    endfunction

    // register shadow, follows every write the block sees
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LOWEST;
            for (int i = 0; i < NUM_LANES; i++)
                depth_reg[i] <= DEPTH_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg     <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_RED_DEPTH:   depth_reg[0] <= cfg_data[DEPTH_W-1:0];
                CFG_GREEN_DEPTH: depth_reg[1] <= cfg_data[DEPTH_W-1:0];
                CFG_BLUE_DEPTH:  depth_reg[2] <= cfg_data[DEPTH_W-1:0];
                CFG_ALPHA_DEPTH: depth_reg[3] <= cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // input transactions -> expected pixels
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            reduced_q.push_back(reduced_pixel(s_tdata));
    end

    // output transactions checked in order
    always @(posedge clk)
    begin
        logic [PIX_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reduced_q.size() == 0)
            begin
                $error("output pixel %h with nothing expected", m_tdata);
                error_count++;
            end
            else
            begin
                want = reduced_q.pop_front();
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    if (m_tdata[i*CH_W +: CH_W] !== want[i*CH_W +: CH_W])
                    begin
                        $error("%s_out: expected %0d, got %0d", lane_name[i],
                               want[i*CH_W +: CH_W], m_tdata[i*CH_W +: CH_W]);
                        error_count++;
                    end
                end
            end
        end
    end

    // output side back-pressure
    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // leaves tvalid high; the next send or a drain decides what follows
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // waits on the clock first so the last accepted pixel is already queued
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reduced_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // writes every index, the unused ones with junk that must be ignored
    task automatic configure(input mode_t m, input logic [DEPTH_W-1:0] rd, gd, bd, ad);
        logic [CFG_DATA_W-1:0] val;
        for (int i = 0; i < 2**CFG_IDX_W; i++)
        begin
            case (i)
                CFG_MODE:        val = {(CFG_DATA_W-MODE_W)'($urandom), m};
                CFG_RED_DEPTH:   val = rd;
                CFG_GREEN_DEPTH: val = gd;
                CFG_BLUE_DEPTH:  val = bd;
                CFG_ALPHA_DEPTH: val = ad;
                default:         val = CFG_DATA_W'($urandom);
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'hFE7F_8001);
        send_pixel(random_pixel());
        drain();
    endtask

    task automatic test_mode_sweep();
        mode_t m;
        for (int k = 0; k < 4; k++)
        begin
            m = mode_t'(k);
            // red at depth zero, alpha alternates full depth and above eight
            configure(m, 4'd0, 4'd1, 4'd7, (k % 2) ? 4'd15 : DEPTH_MAX);
            send_pixel('0);
            send_pixel('1);
            send_pixel(32'h807F_01FE);
            send_pixel(random_pixel());
            drain();
        end
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 5;
            out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            if (ph == 0)
                configure(MODE_DYNAMIC, 4'd0, 4'd0, 4'd0, 4'd0);
            else if (ph == 1)
                configure(MODE_HIGHEST, 4'd15, 4'd15, 4'd15, 4'd15);
            else if (ph == 2)
                configure(MODE_MIDDLE, DEPTH_MAX, 4'd0, DEPTH_MAX, 4'd0);
            else
                configure(mode_t'($urandom_range(0, 3)), random_depth(), random_depth(),
                          random_depth(), random_depth());
            repeat (PHASE_PIX) send_pixel(random_pixel());
            drain();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_mode_sweep();
        test_random_phases();
        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
